[rtl/tfs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tfs_pkg
// Shared types, codes and helpers for the telemetry frame stuffer.
// ----------------------------------------------------------------------------
package tfs_pkg;

    // request mode codes
    localparam logic [1:0] MODE_HEADER = 2'd0;
    localparam logic [1:0] MODE_DATA   = 2'd1;
    localparam logic [1:0] MODE_EMPTY  = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // line bytes
    localparam logic [7:0] START_BYTE    = 8'h7E;
    localparam logic [7:0] ESCAPE_BYTE   = 8'h7D;
    localparam logic [7:0] ESC_OF_START  = 8'h5E;
    localparam logic [7:0] ESC_OF_ESCAPE = 8'h5D;
    localparam logic [7:0] CSUM_BASE     = 8'hFF;
    localparam logic [7:0] ZERO_BYTE     = 8'h00;

    localparam logic [7:0] FRAME_TYPE_RESET = 8'h10;

    // seven frame bytes plus checksum; a header uses the first two slots
    localparam int FRAME_BYTES = 8;
    localparam int HEADER_BYTES = 2;
    localparam int IDX_W = $clog2(FRAME_BYTES);
    // raw sum of seven bytes fits in 11 bits
    localparam int SUM_W = 11;

    localparam int QUEUE_DEPTH = 2;

    // one classified request
    typedef struct packed {
        logic                         hdr;
        logic [FRAME_BYTES-1:0][7:0]  bytes;
    } t_entry;

    // queue status towards the front end
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // end-around-carry fold of a raw sum, returned as the checksum byte
    function automatic logic [7:0] csum_byte(input logic [SUM_W-1:0] t);
        logic [8:0] f1;
        logic [8:0] f2;
        f1 = {1'b0, t[7:0]} + {6'b0, t[SUM_W-1:8]};
        f2 = {1'b0, f1[7:0]} + {8'b0, f1[8]};
        return CSUM_BASE - f2[7:0];
    endfunction

endpackage
`default_nettype wire

[rtl/tfs_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tfs_front
// Accepts requests, builds the raw frame bytes and checksum, feeds the queue.
// ----------------------------------------------------------------------------
module tfs_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [7:0]          i_cfg_data,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [1:0]          i_mode,
    input  wire logic [7:0]          i_sensor_id,
    input  wire logic [15:0]         i_data_type_id,
    input  wire logic [31:0]         i_data_value,
    input  wire tfs_pkg::t_q_stat    i_q_stat,
    output logic                     o_push,
    output tfs_pkg::t_entry          o_entry
);

    logic [7:0]                  r_frame_type;
    logic                        r_valid;
    logic                        r_hdr;
    logic [6:0][7:0]             r_bytes;
    logic [tfs_pkg::SUM_W-1:0]   r_sum;

    logic                        accept;
    logic [6:0][7:0]             n_bytes;
    logic [tfs_pkg::SUM_W-1:0]   n_sum;
    logic [31:0]                 val;

    // stage is free when empty or draining into the queue this cycle
    assign o_push  = r_valid && !i_q_stat.full;
    assign o_stall = r_valid && i_q_stat.full;
    assign accept  = i_valid && !o_stall;

    // classify and build raw bytes
    always_comb begin
        val = (i_mode == tfs_pkg::MODE_EMPTY) ? 32'd0 : i_data_value;
        n_bytes = '0;
        if (i_mode == tfs_pkg::MODE_HEADER) begin
            n_bytes[0] = tfs_pkg::START_BYTE;
            n_bytes[1] = i_sensor_id;
        end else begin
            n_bytes[0] = (i_mode == tfs_pkg::MODE_DATA) ? r_frame_type
                                                        : tfs_pkg::ZERO_BYTE;
            n_bytes[1] = i_data_type_id[7:0];
            n_bytes[2] = i_data_type_id[15:8];
            n_bytes[3] = val[7:0];
            n_bytes[4] = val[15:8];
            n_bytes[5] = val[23:16];
            n_bytes[6] = val[31:24];
        end
        n_sum = '0;
        for (int k = 0; k < 7; k++) begin
            n_sum = n_sum + {3'b0, n_bytes[k]};
        end
    end

    // frame type register and front stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_type <= tfs_pkg::FRAME_TYPE_RESET;
            r_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_frame_type <= i_cfg_data;
            end
            if (accept) begin
                r_valid <= (i_mode != tfs_pkg::MODE_UNUSED);
            end else if (o_push) begin
                r_valid <= 1'b0;
            end
        end
    end

    // payload of the front stage
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hdr   <= (i_mode == tfs_pkg::MODE_HEADER);
            r_bytes <= n_bytes;
            r_sum   <= n_sum;
        end
    end

    // checksum folded on the way into the queue
    always_comb begin
        o_entry.hdr        = r_hdr;
        o_entry.bytes[6:0] = r_bytes;
        o_entry.bytes[7]   = tfs_pkg::csum_byte(r_sum);
    end

endmodule
`default_nettype wire

[rtl/tfs_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tfs_queue
// Short FIFO of classified requests between front and back ends.
// ----------------------------------------------------------------------------
module tfs_queue #(
    parameter int DEPTH = tfs_pkg::QUEUE_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire tfs_pkg::t_entry   i_entry,
    input  wire logic              i_pop,
    output tfs_pkg::t_entry        o_entry,
    output tfs_pkg::t_q_stat       o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tfs_pkg::t_entry   r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_cnt;

    assign o_stat.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_entry      = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

[rtl/tfs_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tfs_back
// Walks the head request byte by byte, escapes frame bytes, drives output.
// ----------------------------------------------------------------------------
module tfs_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tfs_pkg::t_entry   i_head,
    input  wire logic              i_head_valid,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [7:0]             o_out_byte,
    output logic                   o_last_byte
);

    logic [tfs_pkg::IDX_W-1:0]  r_idx;
    logic                       r_esc;
    logic                       r_out_valid;
    logic [7:0]                 r_out_byte;
    logic                       r_out_last;

    logic                       advance;
    logic [7:0]                 cur;
    logic                       special;
    logic                       done_byte;
    logic                       is_last;
    logic [tfs_pkg::IDX_W-1:0]  last_idx;
    logic [7:0]                 n_out_byte;

    assign advance = i_head_valid && (!r_out_valid || !i_stall);

    // next line byte
    always_comb begin
        cur      = i_head.bytes[r_idx];
        special  = !i_head.hdr &&
                   (cur == tfs_pkg::START_BYTE || cur == tfs_pkg::ESCAPE_BYTE);
        last_idx = i_head.hdr ? tfs_pkg::IDX_W'(tfs_pkg::HEADER_BYTES - 1)
                              : tfs_pkg::IDX_W'(tfs_pkg::FRAME_BYTES - 1);
        if (special && !r_esc) begin
            n_out_byte = tfs_pkg::ESCAPE_BYTE;
            done_byte  = 1'b0;
        end else if (r_esc) begin
            n_out_byte = (cur == tfs_pkg::START_BYTE) ? tfs_pkg::ESC_OF_START
                                                      : tfs_pkg::ESC_OF_ESCAPE;
            done_byte  = 1'b1;
        end else begin
            n_out_byte = cur;
            done_byte  = 1'b1;
        end
        is_last = done_byte && (r_idx == last_idx);
    end

    assign o_pop = advance && is_last;

    // byte walker and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_esc       <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
            if (done_byte) begin
                r_esc <= 1'b0;
                r_idx <= is_last ? '0 : r_idx + 1'b1;
            end else begin
                r_esc <= 1'b1;
            end
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_byte <= n_out_byte;
            r_out_last <= is_last;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_last_byte = r_out_last;

endmodule
`default_nettype wire

[rtl/telemetry_frame_stuffer_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// telemetry_frame_stuffer_top
// Turns telemetry requests into escaped serial frame bytes, last byte marked.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  request   in         i_valid / o_stall      i_mode, i_sensor_id,
//                                              i_data_type_id, i_data_value
//  bytes     out        o_valid / i_stall      o_out_byte, o_last_byte
//  config    in         i_cfg_we               i_cfg_data (frame type)
//
//  One byte leaves per cycle while a request is queued and i_stall is low;
//  a header is 2 bytes, a data or empty frame 8 to 16, set by the byte walker
//  in the back end. A taken request reaches valid output by way of the front
//  stage register, then the queue write, then the output register.
//  Reset is synchronous, active low; no clearing pass is needed.
//  Front and back stall independently through a QDEPTH-deep request queue.
// ----------------------------------------------------------------------------
module telemetry_frame_stuffer_top #(
    parameter int QDEPTH = tfs_pkg::QUEUE_DEPTH
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [7:0]   i_cfg_data,
    input  wire logic         i_valid,
    output logic              o_stall,
    input  wire logic [1:0]   i_mode,
    input  wire logic [7:0]   i_sensor_id,
    input  wire logic [15:0]  i_data_type_id,
    input  wire logic [31:0]  i_data_value,
    output logic              o_valid,
    input  wire logic         i_stall,
    output logic [7:0]        o_out_byte,
    output logic              o_last_byte
);

    tfs_pkg::t_q_stat  q_stat;
    tfs_pkg::t_entry   push_entry;
    tfs_pkg::t_entry   head_entry;
    logic              q_push;
    logic              q_pop;

    // front end: accept and classify
    tfs_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_mode         (i_mode),
        .i_sensor_id    (i_sensor_id),
        .i_data_type_id (i_data_type_id),
        .i_data_value   (i_data_value),
        .i_q_stat       (q_stat),
        .o_push         (q_push),
        .o_entry        (push_entry)
    );

    // request queue
    tfs_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (push_entry),
        .i_pop   (q_pop),
        .o_entry (head_entry),
        .o_stat  (q_stat)
    );

    // back end: escape and emit
    tfs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head_entry),
        .i_head_valid (!q_stat.empty),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_last_byte  (o_last_byte)
    );

`ifndef SYNTHESIS
    // queue never written when full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("request queue overflow");

    // queue never read when empty
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("request queue underflow");

    // input side only stalls on a full queue
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> q_stat.full)
        else $error("input stalled with room in queue");

    // output idle after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");
`endif

endmodule
`default_nettype wire
